[rtl/core/rgb_to_hsv_converter_assert.svh]
// assertion macros for the rgb to hsv converter
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// condition must hold at every edge out of reset
`define RTV_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RTV_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rtv_pkg.sv]
// shared constants and types of the rgb to hsv converter
// no dependencies
package rtv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = '1;

  localparam int SECTOR_DEG = 60;
  localparam int FULL_TURN  = 360;
  localparam int PCT_FULL   = 100;

  // result field widths
  localparam int HUE_W = 9;
  localparam int SAT_W = 7;
  localparam int BRI_W = 7;

  // divider widths: quotient bits and numerator bits
  localparam int HUE_QW = HUE_W;
  localparam int PCT_QW = SAT_W;
  localparam int HUE_NW = CHANNEL_BITS + HUE_QW;
  localparam int PCT_NW = CHANNEL_BITS + PCT_QW;
  localparam int DIV_STAGES = HUE_QW;

  // brightness by reciprocal multiplication, exact floor for numerators below 2^PCT_NW
  localparam int     VAL_SHIFT = PCT_NW + CHANNEL_BITS;
  localparam int     VAL_RW    = VAL_SHIFT - CHANNEL_BITS + 1;
  localparam int     VAL_PW    = PCT_NW + VAL_RW;
  localparam longint VAL_RECIP = ((longint'(1) << VAL_SHIFT) + longint'(FULL_SCALE) - 1)
                                 / longint'(FULL_SCALE);

  localparam int IN_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((HUE_W + SAT_W + BRI_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified pixel waiting for the dividers
  typedef struct packed {
    logic [HUE_NW-1:0]       hue_num;
    logic [CHANNEL_BITS-1:0] hue_den;
    logic [PCT_NW-1:0]       sat_num;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [BRI_W-1:0]        val;
  } rtv_job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } rtv_q_status_t;

endpackage

[rtl/core/rtv_front.sv]
// front end: takes a pixel, finds max, min and sector, builds the numerators
// depends on rtv_pkg
module rtv_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rtv_pkg::IN_W-1:0]      in_tdata,
  input  rtv_pkg::rtv_q_status_t        q_status,
  output logic                          push,
  output rtv_pkg::rtv_job_t             push_job
);

  localparam int CB  = rtv_pkg::CHANNEL_BITS;
  localparam int HNW = rtv_pkg::HUE_NW;
  localparam int PNW = rtv_pkg::PCT_NW;
  localparam int VPW = rtv_pkg::VAL_PW;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  logic [CB-1:0]  red, green, blue;
  logic [CB-1:0]  mx, mn, d;
  sector_t        sector;
  logic [HNW-1:0] r_w, g_w, b_w, d_w;
  logic [HNW-1:0] deg60, deg120, deg240, deg360;
  logic [VPW-1:0] val_prod;

  assign red   = in_tdata[CB-1:0];
  assign green = in_tdata[2*CB-1:CB];
  assign blue  = in_tdata[3*CB-1:2*CB];

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  assign deg60  = HNW'(rtv_pkg::SECTOR_DEG);
  assign deg120 = HNW'(2 * rtv_pkg::SECTOR_DEG);
  assign deg240 = HNW'(4 * rtv_pkg::SECTOR_DEG);
  assign deg360 = HNW'(rtv_pkg::FULL_TURN);

  // ties go to red, then green
  always_comb begin
    if (red >= green && red >= blue) begin
      sector = SECT_RED;
      mx     = red;
    end else if (green >= blue) begin
      sector = SECT_GREEN;
      mx     = green;
    end else begin
      sector = SECT_BLUE;
      mx     = blue;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign d   = mx - mn;
  assign r_w = HNW'(red);
  assign g_w = HNW'(green);
  assign b_w = HNW'(blue);
  assign d_w = HNW'(d);

  // 100 * max over full scale via the reciprocal
  assign val_prod = VPW'(PNW'(rtv_pkg::PCT_FULL) * PNW'(mx)) * VPW'(rtv_pkg::VAL_RECIP);

  always_comb begin
    push_job = '0;
    if (d == '0) begin
      // grey pixel: zero over one gives hue zero
      push_job.hue_num = '0;
      push_job.hue_den = CB'(1);
    end else begin
      push_job.hue_den = d;
      unique case (sector)
        SECT_RED: begin
          if (green >= blue) begin
            push_job.hue_num = deg60 * (g_w - b_w);
          end else begin
            push_job.hue_num = deg360 * d_w - deg60 * (b_w - g_w);
          end
        end
        SECT_GREEN: push_job.hue_num = deg120 * d_w + deg60 * b_w - deg60 * r_w;
        SECT_BLUE:  push_job.hue_num = deg240 * d_w + deg60 * r_w - deg60 * g_w;
        default:    push_job.hue_num = '0;
      endcase
    end
    push_job.sat_num = PNW'(rtv_pkg::PCT_FULL) * PNW'(d);
    // black pixel: d is zero too, so zero over one
    push_job.sat_den = (mx == '0) ? CB'(1) : mx;
    push_job.val     = rtv_pkg::BRI_W'(val_prod >> rtv_pkg::VAL_SHIFT);
  end

endmodule

[rtl/core/rtv_queue.sv]
// short queue between the front end and the divider pipeline
// depends on rtv_pkg
module rtv_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rtv_pkg::rtv_job_t      push_job,
  input  logic                   pop_ready,
  output logic                   pop_valid,
  output rtv_pkg::rtv_job_t      pop_job,
  output rtv_pkg::rtv_q_status_t status
);

  localparam int PW = rtv_pkg::QPTR_W;
  localparam int CW = rtv_pkg::QCNT_W;

  rtv_pkg::rtv_job_t mem_r [rtv_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];

  assign status.full  = (cnt_r == CW'(rtv_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign status.count = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(rtv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(rtv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/core/rtv_back.sv]
// back end: pipelined restoring dividers for hue and saturation, brightness rides along
// one hue bit per stage, saturation bits at shifts below PCT_QW, output register at end; depends on rtv_pkg
module rtv_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  rtv_pkg::rtv_job_t         pop_job,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rtv_pkg::OUT_W-1:0] out_tdata
);

  localparam int CB  = rtv_pkg::CHANNEL_BITS;
  localparam int HNW = rtv_pkg::HUE_NW;
  localparam int PNW = rtv_pkg::PCT_NW;
  localparam int HQW = rtv_pkg::HUE_QW;
  localparam int PQW = rtv_pkg::PCT_QW;
  localparam int BW  = rtv_pkg::BRI_W;
  localparam int NS  = rtv_pkg::DIV_STAGES;

  typedef struct packed {
    logic [HNW-1:0] hue_rem;
    logic [CB-1:0]  hue_den;
    logic [HQW-1:0] hue_q;
    logic [PNW-1:0] sat_rem;
    logic [CB-1:0]  sat_den;
    logic [PQW-1:0] sat_q;
    logic [BW-1:0]  val_q;
  } div_stage_t;

  // one compare and subtract per divider; quotient bits enter msb first
  function automatic div_stage_t div_step(div_stage_t x, int sh);
    logic [HNW-1:0] hd;
    logic [PNW-1:0] sd;
    logic           hb, sb;
    div_stage_t     y;
    y  = x;
    hd = HNW'(x.hue_den) << sh;
    hb = (x.hue_rem >= hd);
    if (hb) y.hue_rem = x.hue_rem - hd;
    y.hue_q = {x.hue_q[HQW-2:0], hb};
    if (sh < PQW) begin
      sd = PNW'(x.sat_den) << sh;
      sb = (x.sat_rem >= sd);
      if (sb) y.sat_rem = x.sat_rem - sd;
      y.sat_q = {x.sat_q[PQW-2:0], sb};
    end
    return y;
  endfunction

  div_stage_t                 stage_r [NS];
  logic       [NS-1:0]        vld_r;
  div_stage_t                 step_in [NS];
  div_stage_t                 step_out [NS];
  logic       [NS:0]          adv;
  logic                       out_tvalid_r;
  logic [rtv_pkg::OUT_W-1:0]  out_tdata_r;

  always_comb begin
    step_in[0]         = '0;
    step_in[0].hue_rem = pop_job.hue_num;
    step_in[0].hue_den = pop_job.hue_den;
    step_in[0].sat_rem = pop_job.sat_num;
    step_in[0].sat_den = pop_job.sat_den;
    step_in[0].val_q   = pop_job.val;
  end

  for (genvar s = 1; s < NS; s++) begin : g_link
    assign step_in[s] = stage_r[s-1];
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    assign step_out[s] = div_step(step_in[s], NS - 1 - s);
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NS] = !out_tvalid_r || out_tready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end

  assign pop_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (adv[0]) vld_r[0] <= pop_valid;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
      if (adv[NS]) out_tvalid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) stage_r[s] <= step_out[s];
    end
    if (adv[NS]) begin
      out_tdata_r <= rtv_pkg::OUT_W'({stage_r[NS-1].val_q, stage_r[NS-1].sat_q,
                                      stage_r[NS-1].hue_q});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/core/rgb_to_hsv_converter.sv]
// rgb to hsv converter: one pixel per clock sustained while the output does not stall
// the path runs through the queue register, nine divider stages (one hue quotient bit each) and the
// output register; stalls on the output hold the pipeline, the queue absorbs the input side
// synchronous active-low reset empties the queue and clears all stage valids, no clearing pass
// depends on rtv_pkg, rtv_front, rtv_queue, rtv_back and rgb_to_hsv_converter_assert.svh
`include "rgb_to_hsv_converter_assert.svh"
module rgb_to_hsv_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rtv_pkg::IN_W-1:0]  in_tdata,   // red, green, blue
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rtv_pkg::OUT_W-1:0] out_tdata   // hue, saturation, brightness, zero pad
);

  localparam int HW = rtv_pkg::HUE_W;
  localparam int SW = rtv_pkg::SAT_W;
  localparam int BW = rtv_pkg::BRI_W;

  rtv_pkg::rtv_q_status_t q_status;
  rtv_pkg::rtv_job_t      push_job;
  rtv_pkg::rtv_job_t      pop_job;
  logic                   push;
  logic                   pop_valid;
  logic                   pop_ready;
  logic                   pop_fire;

  rtv_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  rtv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop_ready (pop_ready),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .status    (q_status)
  );

  rtv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign pop_fire = pop_valid && pop_ready;

  `RTV_ASSERT_IMPLIES(a_result_range, out_tvalid, (out_tdata[HW-1:0] < HW'(rtv_pkg::FULL_TURN)) && (out_tdata[HW+SW-1:HW] <= SW'(rtv_pkg::PCT_FULL)) && (out_tdata[HW+SW+BW-1:HW+SW] <= BW'(rtv_pkg::PCT_FULL)), "result field out of range")
  `RTV_ASSERT_HOLDS(a_queue_bound, q_status.count <= rtv_pkg::QCNT_W'(rtv_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `RTV_ASSERT_NEXT(a_queue_fill, push && !pop_fire, q_status.count == $past(q_status.count) + rtv_pkg::QCNT_W'(1), "queue count missed a push")

endmodule
